FILE: rtl/enh_pkg.sv
// Shared constants, types and command/status bundles for the elastic network Hessian unit.
`timescale 1ns / 1ps
`default_nettype none
package enh_pkg;

   // Field widths of the request and response.
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 10;
   localparam int POS_W     = 24;
   localparam int CHAIN_W   = 8;
   localparam int KIND_W    = 2;
   localparam int ENT_W     = 36;
   localparam int NUM_ENT   = 6;

   // Configuration port widths and register values.
   localparam int SPRING_W    = 16;
   localparam int CUT_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 17;
   localparam logic [SPRING_W-1:0] SPRING_RESET = 16'd256;
   localparam logic [CUT_W-1:0]    CUT_RESET    = 17'd15000;

   // Datapath widths.
   localparam int DIFF_W = POS_W + 1;
   localparam int MAG_W  = POS_W + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int D2_W   = PROD_W + 2;
   localparam int CUT2_W = 2 * CUT_W;
   localparam int KK_W   = SPRING_W + 8;
   localparam int QUO_W  = KK_W;
   localparam int DIV_STEPS  = KK_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int DEF_MAX_RESIDUES = 1024;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PAIR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

   // Contact kinds.
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAME  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CROSS = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_SAME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_CROSS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_SAME     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT_CROSS    = 2'd3;

   // Response source selection.
   localparam logic [1:0] OSEL_ZERO = 2'd0;
   localparam logic [1:0] OSEL_DIAG = 2'd1;
   localparam logic [1:0] OSEL_PAIR = 2'd2;

   typedef logic [NUM_ENT-1:0][ENT_W-1:0] ent_row_type;

   typedef struct packed {
      logic [CHAIN_W-1:0] chain;
      logic [POS_W-1:0]   z;
      logic [POS_W-1:0]   y;
      logic [POS_W-1:0]   x;
   } pos_row_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       load_wr;
      logic       pos_rd_a;
      logic       pos_rd_b;
      logic       diff_ld;
      logic       mul_ld;
      logic       sum_ld;
      logic       div_start;
      logic       div_step;
      logic       diag_rd_a;
      logic       diag_rd_b;
      logic       diag_wr_a;
      logic       diag_wr_b;
      logic       clr_step;
      logic       out_load;
      logic [1:0] out_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              ok_a;
      logic              ok_b;
      logic              same_idx;
      logic              contact;
      logic              clr_last;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/enh_div.sv
// Radix-2 divider lane computing floor(kk * num / den) one multiplier bit per cycle while step is high.
`timescale 1ns / 1ps
`default_nettype none
module enh_div (
   input  wire logic                        clock,
   input  wire logic                        start,
   input  wire logic                        step,
   input  wire logic [enh_pkg::KK_W-1:0]    kk,
   input  wire logic [enh_pkg::PROD_W-1:0]  num,
   input  wire logic [enh_pkg::D2_W-1:0]    den,
   output logic      [enh_pkg::QUO_W-1:0]   quo
);

   localparam int T_W = enh_pkg::D2_W + 2;

   logic [enh_pkg::D2_W-1:0]  rem_ff, rem_in;
   logic [enh_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [enh_pkg::KK_W-1:0]  bits_ff, bits_in;
   logic [T_W-1:0]            trial;
   logic [T_W-1:0]            den1;
   logic [T_W-1:0]            den2;

   // Since num <= den and rem < den, the partial value stays below three times den.
   always_comb begin
      trial = T_W'({rem_ff, 1'b0}) + (bits_ff[enh_pkg::KK_W-1] ? T_W'(num) : '0);
      den1  = T_W'(den);
      den2  = T_W'({den, 1'b0});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      bits_in = bits_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         bits_in = kk;
      end else if (step) begin
         bits_in = {bits_ff[enh_pkg::KK_W-2:0], 1'b0};
         if (trial >= den2) begin
            rem_in = enh_pkg::D2_W'(trial - den2);
            quo_in = {quo_ff[enh_pkg::QUO_W-2:0], 1'b0} + enh_pkg::QUO_W'(2);
         end else if (trial >= den1) begin
            rem_in = enh_pkg::D2_W'(trial - den1);
            quo_in = {quo_ff[enh_pkg::QUO_W-2:0], 1'b0} + enh_pkg::QUO_W'(1);
         end else begin
            rem_in = enh_pkg::D2_W'(trial);
            quo_in = {quo_ff[enh_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   // Working registers of the lane.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bits_ff <= bits_in;
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

FILE: rtl/enh_ctrl.sv
// Controller state machine sequencing load, pair and read requests.
`timescale 1ns / 1ps
`default_nettype none
module enh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output enh_pkg::cmd_type          cmd,
   input  wire enh_pkg::status_type  st
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_RD_A   = 4'd3;
   localparam logic [3:0] S_RD_B   = 4'd4;
   localparam logic [3:0] S_DIFF   = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_SUM    = 4'd7;
   localparam logic [3:0] S_CHK    = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_DRD_A  = 4'd10;
   localparam logic [3:0] S_DWR_A  = 4'd11;
   localparam logic [3:0] S_DRD_B  = 4'd12;
   localparam logic [3:0] S_DWR_B  = 4'd13;
   localparam logic [3:0] S_RDDIAG = 4'd14;
   localparam logic [3:0] S_OUT    = 4'd15;

   logic [3:0]                    state_ff, state_in;
   logic [1:0]                    osel_ff, osel_in;
   logic [enh_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      osel_in    = osel_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = (state_ff == S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            osel_in  = enh_pkg::OSEL_ZERO;
            state_in = S_OUT;
            case (st.mode)
               enh_pkg::MODE_LOAD: begin
                  cmd.load_wr = st.ok_a;
               end
               enh_pkg::MODE_PAIR: begin
                  if (st.ok_a && st.ok_b && !st.same_idx) begin
                     state_in = S_RD_A;
                  end
               end
               enh_pkg::MODE_READ: begin
                  if (st.ok_a) begin
                     state_in = S_RDDIAG;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_RDDIAG: begin
            cmd.diag_rd_a = 1'b1;
            osel_in       = enh_pkg::OSEL_DIAG;
            state_in      = S_OUT;
         end
         S_RD_A: begin
            cmd.pos_rd_a = 1'b1;
            state_in     = S_RD_B;
         end
         S_RD_B: begin
            cmd.pos_rd_b = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_ld = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul_ld = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum_ld = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            if (st.contact) begin
               cmd.div_start = 1'b1;
               div_cnt_in    = '0;
               state_in      = S_DIV;
            end else begin
               osel_in  = enh_pkg::OSEL_ZERO;
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + enh_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == enh_pkg::DIV_CNT_W'(enh_pkg::DIV_STEPS - 1)) begin
               state_in = S_DRD_A;
            end
         end
         S_DRD_A: begin
            cmd.diag_rd_a = 1'b1;
            state_in      = S_DWR_A;
         end
         S_DWR_A: begin
            cmd.diag_wr_a = 1'b1;
            state_in      = S_DRD_B;
         end
         S_DRD_B: begin
            cmd.diag_rd_b = 1'b1;
            state_in      = S_DWR_B;
         end
         S_DWR_B: begin
            cmd.diag_wr_b = 1'b1;
            osel_in       = enh_pkg::OSEL_PAIR;
            state_in      = S_OUT;
         end
         S_OUT: begin
            cmd.out_sel = osel_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set when the output register loads, cleared when taken.
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         osel_ff      <= enh_pkg::OSEL_ZERO;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         osel_ff      <= osel_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register is never overwritten while it holds an untaken response.
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register loaded while occupied");

   // An accepted request is always decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

   // The divider step count stays within the quotient width.
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff <= enh_pkg::DIV_CNT_W'(enh_pkg::DIV_STEPS - 1)))
      else $error("divider step count out of range");

   // A new response only appears from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside the output state");

endmodule
`default_nettype wire

FILE: rtl/enh_datapath.sv
// Datapath: residue and diagonal memories, distance arithmetic, divider lanes, output register.
`timescale 1ns / 1ps
`default_nettype none
module enh_datapath #(
   parameter int MAX_RESIDUES = enh_pkg::DEF_MAX_RESIDUES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire enh_pkg::cmd_type                  cmd,
   output enh_pkg::status_type                    st,
   input  wire logic [enh_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [enh_pkg::IDX_W-1:0]         req_first_index,
   input  wire logic [enh_pkg::IDX_W-1:0]         req_second_index,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_z,
   input  wire logic [enh_pkg::CHAIN_W-1:0]       req_chain_id,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [enh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [enh_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [enh_pkg::KIND_W-1:0]             rsp_kind,
   output enh_pkg::ent_row_type                   rsp_ent
);

   localparam int AW = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;

   // Captured request.
   logic [enh_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [enh_pkg::IDX_W-1:0]   ia_ff, ia_in, ib_ff, ib_in;
   logic [enh_pkg::POS_W-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [enh_pkg::CHAIN_W-1:0] chain_ff, chain_in;

   // Configuration registers.
   logic [enh_pkg::SPRING_W-1:0] spring_same_ff, spring_same_in;
   logic [enh_pkg::SPRING_W-1:0] spring_cross_ff, spring_cross_in;
   logic [enh_pkg::CUT_W-1:0]    cut_same_ff, cut_same_in;
   logic [enh_pkg::CUT_W-1:0]    cut_cross_ff, cut_cross_in;

   // Arithmetic pipeline registers.
   enh_pkg::pos_row_type                    pos_a_ff, pos_a_in;
   logic signed [enh_pkg::DIFF_W-1:0]       dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic                                    same_ff, same_in;
   logic [enh_pkg::NUM_ENT-1:0][enh_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [enh_pkg::NUM_ENT-1:0]             pos_ent_ff, pos_ent_in;
   logic [enh_pkg::CUT2_W-1:0]              cut2_ff, cut2_in;
   logic [enh_pkg::KK_W-1:0]                kk_ff, kk_in;
   logic [enh_pkg::D2_W-1:0]                d2_ff, d2_in;
   logic [AW-1:0]                           clr_addr_ff, clr_addr_in;
   logic [enh_pkg::KIND_W-1:0]              rsp_kind_ff, rsp_kind_in;
   enh_pkg::ent_row_type                    rsp_ent_ff, rsp_ent_in;

   // Memories and their registered read data.
   enh_pkg::pos_row_type pos_mem_ff [MAX_RESIDUES];
   enh_pkg::pos_row_type pos_rd_ff;
   enh_pkg::ent_row_type diag_mem_ff [MAX_RESIDUES];
   enh_pkg::ent_row_type diag_rd_ff;

   logic [AW-1:0]                   addr_a, addr_b;
   logic [enh_pkg::MAG_W-1:0]       mx, my, mz;
   logic [enh_pkg::CUT_W-1:0]       cut_sel;
   logic [enh_pkg::SPRING_W-1:0]    spring_sel;
   logic [enh_pkg::NUM_ENT-1:0][enh_pkg::QUO_W-1:0] quo;
   enh_pkg::ent_row_type            ent;
   enh_pkg::ent_row_type            row_sub;
   logic                            pos_we, pos_re;
   logic [AW-1:0]                   pos_ra;
   logic                            diag_we, diag_re;
   logic [AW-1:0]                   diag_wa, diag_ra;
   enh_pkg::ent_row_type            diag_wd;
   logic                            csr_wr;

   assign addr_a = AW'(ia_ff);
   assign addr_b = AW'(ib_ff);
   assign csr_wr = csr_valid & csr_ready;

   // Status toward the controller.
   always_comb begin
      st.mode     = mode_ff;
      st.ok_a     = (32'(ia_ff) < MAX_RESIDUES);
      st.ok_b     = (32'(ib_ff) < MAX_RESIDUES);
      st.same_idx = (ia_ff == ib_ff);
      st.contact  = (d2_ff != '0) && (d2_ff < enh_pkg::D2_W'(cut2_ff));
      st.clr_last = (32'(clr_addr_ff) == MAX_RESIDUES - 1);
   end

   // Magnitudes of the coordinate differences and the selected constants.
   always_comb begin
      mx = dx_ff[enh_pkg::DIFF_W-1] ? enh_pkg::MAG_W'(-dx_ff) : enh_pkg::MAG_W'(dx_ff);
      my = dy_ff[enh_pkg::DIFF_W-1] ? enh_pkg::MAG_W'(-dy_ff) : enh_pkg::MAG_W'(dy_ff);
      mz = dz_ff[enh_pkg::DIFF_W-1] ? enh_pkg::MAG_W'(-dz_ff) : enh_pkg::MAG_W'(dz_ff);
      cut_sel    = same_ff ? cut_same_ff : cut_cross_ff;
      spring_sel = same_ff ? spring_same_ff : spring_cross_ff;
   end

   // Signed entries from the quotients, and the diagonal row after subtraction.
   always_comb begin
      for (int n = 0; n < enh_pkg::NUM_ENT; n++) begin
         ent[n] = pos_ent_ff[n] ? enh_pkg::ENT_W'(quo[n])
                                : enh_pkg::ENT_W'(-enh_pkg::ENT_W'(quo[n]));
         row_sub[n] = diag_rd_ff[n] - ent[n];
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      mode_in  = mode_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pz_in    = pz_ff;
      chain_in = chain_ff;
      spring_same_in  = spring_same_ff;
      spring_cross_in = spring_cross_ff;
      cut_same_in     = cut_same_ff;
      cut_cross_in    = cut_cross_ff;
      pos_a_in   = pos_a_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      dz_in      = dz_ff;
      same_in    = same_ff;
      prod_in    = prod_ff;
      pos_ent_in = pos_ent_ff;
      cut2_in    = cut2_ff;
      kk_in      = kk_ff;
      d2_in      = d2_ff;
      clr_addr_in = clr_addr_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_ent_in  = rsp_ent_ff;

      if (cmd.capture) begin
         mode_in  = req_mode;
         ia_in    = req_first_index;
         ib_in    = req_second_index;
         px_in    = req_pos_x;
         py_in    = req_pos_y;
         pz_in    = req_pos_z;
         chain_in = req_chain_id;
      end

      if (csr_wr) begin
         case (csr_index)
            enh_pkg::CSR_SPRING_SAME:  spring_same_in  = csr_data[enh_pkg::SPRING_W-1:0];
            enh_pkg::CSR_SPRING_CROSS: spring_cross_in = csr_data[enh_pkg::SPRING_W-1:0];
            enh_pkg::CSR_CUT_SAME:     cut_same_in     = csr_data[enh_pkg::CUT_W-1:0];
            enh_pkg::CSR_CUT_CROSS:    cut_cross_in    = csr_data[enh_pkg::CUT_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.pos_rd_b) begin
         pos_a_in = pos_rd_ff;
      end

      // Coordinate differences, first residue minus second.
      if (cmd.diff_ld) begin
         dx_in = enh_pkg::DIFF_W'($signed(pos_a_ff.x)) - enh_pkg::DIFF_W'($signed(pos_rd_ff.x));
         dy_in = enh_pkg::DIFF_W'($signed(pos_a_ff.y)) - enh_pkg::DIFF_W'($signed(pos_rd_ff.y));
         dz_in = enh_pkg::DIFF_W'($signed(pos_a_ff.z)) - enh_pkg::DIFF_W'($signed(pos_rd_ff.z));
         same_in = (pos_a_ff.chain == pos_rd_ff.chain);
      end

      // Products of magnitudes, squared cutoff and scaled spring constant.
      if (cmd.mul_ld) begin
         prod_in[0] = mx * mx;
         prod_in[1] = my * my;
         prod_in[2] = mz * mz;
         prod_in[3] = mx * my;
         prod_in[4] = mx * mz;
         prod_in[5] = my * mz;
         pos_ent_in[0] = 1'b0;
         pos_ent_in[1] = 1'b0;
         pos_ent_in[2] = 1'b0;
         pos_ent_in[3] = (dx_ff[enh_pkg::DIFF_W-1] != dy_ff[enh_pkg::DIFF_W-1])
                         && (dx_ff != '0) && (dy_ff != '0);
         pos_ent_in[4] = (dx_ff[enh_pkg::DIFF_W-1] != dz_ff[enh_pkg::DIFF_W-1])
                         && (dx_ff != '0) && (dz_ff != '0);
         pos_ent_in[5] = (dy_ff[enh_pkg::DIFF_W-1] != dz_ff[enh_pkg::DIFF_W-1])
                         && (dy_ff != '0) && (dz_ff != '0);
         cut2_in = cut_sel * cut_sel;
         kk_in   = {spring_sel, 8'd0};
      end

      // Squared distance.
      if (cmd.sum_ld) begin
         d2_in = enh_pkg::D2_W'(prod_ff[0]) + enh_pkg::D2_W'(prod_ff[1])
               + enh_pkg::D2_W'(prod_ff[2]);
      end

      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end

      // Response register.
      if (cmd.out_load) begin
         case (cmd.out_sel)
            enh_pkg::OSEL_PAIR: begin
               rsp_kind_in = same_ff ? enh_pkg::KIND_SAME : enh_pkg::KIND_CROSS;
               rsp_ent_in  = ent;
            end
            enh_pkg::OSEL_DIAG: begin
               rsp_kind_in = enh_pkg::KIND_NONE;
               rsp_ent_in  = diag_rd_ff;
            end
            default: begin
               rsp_kind_in = enh_pkg::KIND_NONE;
               rsp_ent_in  = '0;
            end
         endcase
      end
   end

   // Registers with a defined reset: configuration and the clearing address.
   always_ff @(posedge clock) begin
      if (reset) begin
         spring_same_ff  <= enh_pkg::SPRING_RESET;
         spring_cross_ff <= enh_pkg::SPRING_RESET;
         cut_same_ff     <= enh_pkg::CUT_RESET;
         cut_cross_ff    <= enh_pkg::CUT_RESET;
         clr_addr_ff     <= '0;
      end else begin
         spring_same_ff  <= spring_same_in;
         spring_cross_ff <= spring_cross_in;
         cut_same_ff     <= cut_same_in;
         cut_cross_ff    <= cut_cross_in;
         clr_addr_ff     <= clr_addr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      chain_ff    <= chain_in;
      pos_a_ff    <= pos_a_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      same_ff     <= same_in;
      prod_ff     <= prod_in;
      pos_ent_ff  <= pos_ent_in;
      cut2_ff     <= cut2_in;
      kk_ff       <= kk_in;
      d2_ff       <= d2_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ent_ff  <= rsp_ent_in;
   end

   // Residue position and chain memory.
   assign pos_we = cmd.load_wr;
   assign pos_re = cmd.pos_rd_a | cmd.pos_rd_b;
   assign pos_ra = cmd.pos_rd_b ? addr_b : addr_a;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem_ff[addr_a] <= {chain_ff, pz_ff, py_ff, px_ff};
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem_ff[pos_ra];
      end
   end

   // Diagonal sum memory: cleared after reset and on load, updated per contact.
   assign diag_we = cmd.clr_step | cmd.load_wr | cmd.diag_wr_a | cmd.diag_wr_b;
   assign diag_wa = cmd.clr_step ? clr_addr_ff : (cmd.diag_wr_b ? addr_b : addr_a);
   assign diag_wd = (cmd.diag_wr_a | cmd.diag_wr_b) ? row_sub : '0;
   assign diag_re = cmd.diag_rd_a | cmd.diag_rd_b;
   assign diag_ra = cmd.diag_rd_b ? addr_b : addr_a;

   always_ff @(posedge clock) begin
      if (diag_we) begin
         diag_mem_ff[diag_wa] <= diag_wd;
      end
      if (diag_re) begin
         diag_rd_ff <= diag_mem_ff[diag_ra];
      end
   end

   // One divider lane per Hessian entry.
   for (genvar g = 0; g < enh_pkg::NUM_ENT; g++) begin : g_lane
      enh_div u_div (
         .clock (clock),
         .start (cmd.div_start),
         .step  (cmd.div_step),
         .kk    (kk_ff),
         .num   (prod_ff[g]),
         .den   (d2_ff),
         .quo   (quo[g])
      );
   end

   assign rsp_kind = rsp_kind_ff;
   assign rsp_ent  = rsp_ent_ff;

endmodule
`default_nettype wire

FILE: rtl/elastic_network_hessian_unit.sv
// Top level of the elastic network Hessian unit: controller, datapath and ports.
// A load response follows decode directly, a read response follows a diagonal row read.
// A pair with a contact runs the 24-step divider lanes plus two read-modify-write passes
// on the diagonal memory; a pair without contact skips both, and a self pair or an
// out-of-range index answers straight from decode. The next request can be accepted in the
// cycle after the response loads, while it waits. After reset a clearing pass zeroes the diagonal sums first.
`timescale 1ns / 1ps
`default_nettype none
module elastic_network_hessian_unit #(
   parameter int MAX_RESIDUES = enh_pkg::DEF_MAX_RESIDUES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [enh_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [enh_pkg::IDX_W-1:0]         req_first_index,
   input  wire logic [enh_pkg::IDX_W-1:0]         req_second_index,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [enh_pkg::POS_W-1:0]  req_pos_z,
   input  wire logic [enh_pkg::CHAIN_W-1:0]       req_chain_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [enh_pkg::KIND_W-1:0]             rsp_contact_kind,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_xx,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_yy,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_zz,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_xy,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_xz,
   output logic signed [enh_pkg::ENT_W-1:0]       rsp_entry_yz,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [enh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [enh_pkg::CSR_DATA_W-1:0]    csr_data
);

   enh_pkg::cmd_type     cmd;
   enh_pkg::status_type  st;
   enh_pkg::ent_row_type rsp_ent;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencing.
   enh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // Storage and arithmetic.
   enh_datapath #(
      .MAX_RESIDUES (MAX_RESIDUES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_mode         (req_mode),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_chain_id     (req_chain_id),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_kind         (rsp_contact_kind),
      .rsp_ent          (rsp_ent)
   );

   // Response fields in entry order xx, yy, zz, xy, xz, yz.
   assign rsp_entry_xx = rsp_ent[0];
   assign rsp_entry_yy = rsp_ent[1];
   assign rsp_entry_zz = rsp_ent[2];
   assign rsp_entry_xy = rsp_ent[3];
   assign rsp_entry_xz = rsp_ent[4];
   assign rsp_entry_yz = rsp_ent[5];

endmodule
`default_nettype wire
